FILE: rtl/core/piqt_pkg.sv
// Shared types, constants and sequencer states of the point-in-quad test.
`timescale 1ns / 1ps
package piqt_pkg;

    // Polygon corners that take part in the test (three or four).
    localparam int CORNER_COUNT = 4;
    // Configuration registers are always stored for four corners.
    localparam int REG_COUNT    = 8;
    localparam int REG_IDX_W    = $clog2(REG_COUNT);
    localparam int CFG_IDX_W    = REG_IDX_W + 1;

    localparam int COORD_W      = 16;
    localparam int POINT_W      = 12;
    localparam int FRAC_W       = 4;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int EDGE_W       = $clog2(CORNER_COUNT);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [POINT_W-1:0] t_point;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef t_coord t_corner_vec [CORNER_COUNT];

    // Command from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic              en;
        logic              sub;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
    } t_mac_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LHS,
        ST_RHS,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/core/point_in_quad_test.sv
// Top level of the point-in-quad test: registers, handshakes and result stage.
`timescale 1ns / 1ps
// Even-odd crossing-number test of a pixel point against a polygon of
// CORNER_COUNT corners (four by default) held in eight configuration
// registers (corner0_x, corner0_y, ... corner3_x, corner3_y at indexes 0 to 7,
// signed Q12.4, reset to 0; writes to indexes 8 and above are ignored). A query
// transaction carries signed whole-pixel coordinates; one result transaction
// per query returns inside_res. Each edge is handled by one shared 17x17
// multiply-accumulate unit in three steps (lhs product, subtract rhs product,
// sign test and flag toggle). A query occupies the block from acceptance
// until its result is loaded into the result register, which waits while an
// earlier result is still held there; the input is not ready during that
// time. The input opens in the cycle after the result register is loaded.
// The result sits in an output register and the next query may be accepted
// while it waits. The crossing test is exact: no division is used, and a
// point exactly on an edge crossing counts as not left of it. Configuration
// must only be written while no query is in flight.
module point_in_quad_test (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [piqt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [piqt_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [piqt_pkg::POINT_W-1:0] i_point_x,
    input  logic signed [piqt_pkg::POINT_W-1:0] i_point_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_inside_res
);
    import piqt_pkg::*;

    t_coord      r_cfg [REG_COUNT];
    t_corner_vec w_cx;
    t_corner_vec w_cy;
    t_mac_cmd    w_cmd;
    t_acc        w_acc;
    logic        w_idle;
    logic        w_done;
    logic        w_inside;
    logic        w_start;
    logic        w_slot_free;
    logic        r_out_valid;
    logic        r_out_inside;

    // The register file always accepts a write in the same cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            r_cfg[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Corner k uses x from register 2k and y from register 2k+1.
    for (genvar k = 0; k < CORNER_COUNT; k++) begin : g_corner
        assign w_cx[k] = r_cfg[2 * k];
        assign w_cy[k] = r_cfg[2 * k + 1];
    end

    // A query is taken whenever the sequencer is idle, even if the previous
    // result has not yet been collected.
    assign o_in_ready = w_idle;
    assign w_start    = i_in_valid && w_idle;

    // The result stage is free when empty or being emptied in this cycle.
    assign w_slot_free = !r_out_valid || i_out_ready;

    piqt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_cx        (w_cx),
        .i_cy        (w_cy),
        .i_acc       (w_acc),
        .i_slot_free (w_slot_free),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_inside    (w_inside)
    );

    piqt_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_acc (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_slot_free) begin
            r_out_inside <= w_inside;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;

endmodule

FILE: rtl/core/piqt_mac.sv
// Shared signed multiply-accumulate unit used once per operand pair.
`timescale 1ns / 1ps
module piqt_mac (
    input  logic              i_clk,
    input  piqt_pkg::t_mac_cmd i_cmd,
    output piqt_pkg::t_acc    o_acc
);
    import piqt_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    t_acc                     r_acc;
    t_acc                     n_acc;

    assign w_prod = i_cmd.a * i_cmd.b;

    // A load starts a new sum; a subtract removes the second product from it.
    always_comb begin
        n_acc = r_acc;
        if (i_cmd.en) begin
            if (i_cmd.sub) begin
                n_acc = r_acc - ACC_W'(w_prod);
            end else begin
                n_acc = ACC_W'(w_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/core/piqt_seq.sv
// Edge sequencer: walks the polygon edges and drives the shared MAC unit.
`timescale 1ns / 1ps
module piqt_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  piqt_pkg::t_point      i_point_x,
    input  piqt_pkg::t_point      i_point_y,
    input  piqt_pkg::t_corner_vec i_cx,
    input  piqt_pkg::t_corner_vec i_cy,
    input  piqt_pkg::t_acc        i_acc,
    input  logic                  i_slot_free,
    output piqt_pkg::t_mac_cmd    o_cmd,
    output logic                  o_idle,
    output logic                  o_done,
    output logic                  o_inside
);
    import piqt_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [EDGE_W-1:0]   r_edge;
    logic [EDGE_W-1:0]   n_edge;
    logic                r_inside;
    logic                n_inside;
    t_coord              r_px;
    t_coord              r_py;

    logic [EDGE_W-1:0]   w_prev;
    logic                w_last;
    t_coord              w_xi;
    t_coord              w_yi;
    t_coord              w_xj;
    t_coord              w_yj;
    logic                w_straddle;
    logic                w_dy_neg;
    logic                w_left;

    // Edge runs from corner j (the previous one, cyclically) to corner i.
    assign w_prev = (r_edge == '0) ? EDGE_W'(CORNER_COUNT - 1) : r_edge - EDGE_W'(1);
    assign w_last = (r_edge == EDGE_W'(CORNER_COUNT - 1));
    assign w_xi   = i_cx[r_edge];
    assign w_yi   = i_cy[r_edge];
    assign w_xj   = i_cx[w_prev];
    assign w_yj   = i_cy[w_prev];

    assign w_straddle = ((w_yi <= r_py) && (r_py < w_yj)) ||
                        ((w_yj <= r_py) && (r_py < w_yi));
    assign w_dy_neg   = (w_yj < w_yi);
    // The accumulator holds lhs - rhs; the sense flips with the sign of dy.
    assign w_left     = w_dy_neg ? (!i_acc[ACC_W-1] && (i_acc != '0))
                                 : i_acc[ACC_W-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LHS;
                end
            end
            ST_LHS:  n_state = ST_RHS;
            ST_RHS:  n_state = ST_EVAL;
            ST_EVAL: n_state = w_last ? ST_DONE : ST_LHS;
            ST_DONE: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        n_edge   = r_edge;
        n_inside = r_inside;
        case (r_state)
            ST_IDLE: begin
                n_edge   = '0;
                n_inside = 1'b0;
            end
            ST_LHS: begin
                o_cmd.en  = 1'b1;
                o_cmd.sub = 1'b0;
                o_cmd.a   = DIFF_W'(r_px) - DIFF_W'(w_xi);
                o_cmd.b   = DIFF_W'(w_yj) - DIFF_W'(w_yi);
            end
            ST_RHS: begin
                o_cmd.en  = 1'b1;
                o_cmd.sub = 1'b1;
                o_cmd.a   = DIFF_W'(w_xj) - DIFF_W'(w_xi);
                o_cmd.b   = DIFF_W'(r_py) - DIFF_W'(w_yi);
            end
            ST_EVAL: begin
                n_inside = r_inside ^ (w_straddle && w_left);
                n_edge   = r_edge + EDGE_W'(1);
            end
            ST_DONE: begin
                n_edge = '0;
            end
            default: begin
                n_edge = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_edge   <= '0;
            r_inside <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_edge   <= n_edge;
            r_inside <= n_inside;
        end
    end

    // Query point scaled from whole pixels to Q12.4.
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == ST_IDLE)) begin
            r_px <= {i_point_x, {FRAC_W{1'b0}}};
            r_py <= {i_point_y, {FRAC_W{1'b0}}};
        end
    end

    assign o_idle   = (r_state == ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_inside = r_inside;

endmodule

FILE: rtl/core/piqt_checker.sv
// Port-level checker for the point-in-quad test and its bind statement.
`timescale 1ns / 1ps
module piqt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_inside_res
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // One query at a time: the input closes right after a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted query");

    // Each edge passes through the lhs, rhs and evaluation states, so no result appears right away.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid ##1 !o_out_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_inside_res))
        else $error("result changed while stalled");

endmodule

bind point_in_quad_test piqt_checker u_piqt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_inside_res (o_inside_res)
);
